// File: rtl/fwmrp_pkg.sv
// ----------------------------------------------------------------------------
// fwmrp_pkg
// Shared types, register indexes, matrix constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package fwmrp_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int NW               = 4;

  localparam logic [2:0] REG_PROP      = 3'd0;
  localparam logic [2:0] REG_INTEG     = 3'd1;
  localparam logic [2:0] REG_DERIV     = 3'd2;
  localparam logic [2:0] REG_RATE      = 3'd3;
  localparam logic [2:0] REG_WINDOWED  = 3'd4;
  localparam logic [2:0] REG_STEP_TIME = 3'd5;
  localparam logic [2:0] REG_STEP_RATE = 3'd6;

  // lane sequencer steps
  localparam logic [3:0] OP_K    = 4'd0;
  localparam logic [3:0] OP_KM   = 4'd1;
  localparam logic [3:0] OP_KT   = 4'd2;
  localparam logic [3:0] OP_D    = 4'd3;
  localparam logic [3:0] OP_TERM = 4'd4;
  localparam logic [3:0] OP_P    = 4'd5;
  localparam logic [3:0] OP_I    = 4'd6;
  localparam logic [3:0] OP_DD   = 4'd7;
  localparam logic [3:0] OP_L    = 4'd8;
  localparam logic [3:0] OP_M2_0 = 4'd9;
  localparam logic [3:0] OP_LAST = 4'd12;

  localparam logic signed [31:0] INV_M1 [NW][NW] = '{
    '{ 32'sd515396,  -32'sd264677,  32'sd70599,   -32'sd219580},
    '{-32'sd330176,   32'sd641561, -32'sd295279,   32'sd144687},
    '{ -32'sd18871,  -32'sd134486,  32'sd445603,  -32'sd117843},
    '{-32'sd131533,   32'sd51540,  -32'sd71404,    32'sd459025}
  };

  localparam logic signed [31:0] MODEL_M2 [NW][NW] = '{
    '{32'sd1215073092, 32'sd79161616,  32'sd296996989, 32'sd93173947},
    '{32'sd278340724,  32'sd796367467, 32'sd224948912, 32'sd39030515},
    '{32'sd38815767,   32'sd77631534,  32'sd804205783, 32'sd77685221},
    '{32'sd190535487,  32'sd38949985,  32'sd77738908,  32'sd901352574}
  };

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic signed [31:0] deriv_gain;
    logic signed [31:0] model_rate;
    logic               windowed_integral;
    logic [30:0]        step_time;
    logic [30:0]        step_rate;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic clr_en;
  } lane_ctl_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] drive_sum;
  } lane_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [35:0] rnd28(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd134217728;
    return t[63:28];
  endfunction

endpackage

// File: rtl/fwmrp_lane.sv
// ----------------------------------------------------------------------------
// fwmrp_lane
// One wheel: first-order speed model, error terms, integral window and PID
// sum, sequenced over one shared registered multiplier.
// ----------------------------------------------------------------------------
module fwmrp_lane import fwmrp_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int LANE         = 0,
  localparam int HW          = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int WS_W        = 33 + HW
) (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctl_t          ctl,
  input  logic [HW-1:0]      addr,
  input  cfg_t               cfg,
  input  logic signed [31:0] target,
  input  logic signed [31:0] meas [NW],
  output lane_stat_t         stat
);

  logic signed [31:0] mem [WINDOW_DEPTH];
  logic signed [31:0] old_entry;

  logic               busy, phase;
  logic [3:0]         step;
  logic signed [63:0] prod;
  logic signed [31:0] k1, k2, model, prior, integ, e, d, dd, mt;
  logic signed [47:0] a_tmp;
  logic signed [51:0] acc;
  logic signed [WS_W-1:0] wsum;
  logic signed [31:0] drive_sum;
  logic               done;

  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] r16;
  logic signed [35:0] r28;
  logic signed [51:0] rsel;
  logic signed [31:0] term, m_new, e_new;
  logic signed [WS_W-1:0] wsum_next;
  logic               wr_en;
  logic [1:0]         col;

  assign col = 2'(step - OP_M2_0);

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (step)
      OP_K:    begin mul_a = $signed({1'b0, cfg.step_time}); mul_b = cfg.model_rate; end
      OP_KM:   begin mul_a = k1;             mul_b = model; end
      OP_KT:   begin mul_a = k2;             mul_b = target; end
      OP_D:    begin mul_a = dd;             mul_b = $signed({1'b0, cfg.step_rate}); end
      OP_TERM: begin mul_a = e;              mul_b = $signed({1'b0, cfg.step_time}); end
      OP_P:    begin mul_a = cfg.prop_gain;  mul_b = e; end
      OP_I:    begin mul_a = cfg.integ_gain; mul_b = integ; end
      OP_DD:   begin mul_a = cfg.deriv_gain; mul_b = d; end
      OP_L:    begin mul_a = cfg.model_rate; mul_b = mt; end
      default: begin mul_a = MODEL_M2[LANE][col]; mul_b = meas[col]; end
    endcase
  end

  assign r16       = rnd16(prod);
  assign r28       = rnd28(prod);
  assign rsel      = (step >= OP_M2_0) ? 52'(r28) : 52'(r16);
  assign term      = sat32(64'(r16));
  assign m_new     = sat32(64'(a_tmp) - 64'(r16));
  assign e_new     = sat32(64'(m_new) - 64'(meas[LANE]));
  assign wsum_next = wsum - WS_W'(old_entry) + WS_W'(term);
  assign wr_en     = busy && phase && (step == OP_TERM) && cfg.windowed_integral;

  always_ff @(posedge clk) begin
    if (ctl.clr_en) begin
      mem[addr] <= 32'sd0;
    end else if (wr_en) begin
      mem[addr] <= term;
    end
    old_entry <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      step  <= OP_K;
      done  <= 1'b0;
      model <= '0;
      prior <= '0;
      integ <= '0;
      wsum  <= '0;
    end else begin
      done <= busy && phase && !ctl.start && (step == OP_LAST);
      if (ctl.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        step  <= OP_K;
      end else if (busy) begin
        if (!phase) begin
          prod  <= mul_a * mul_b;
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          case (step)
            OP_K: begin
              k2 <= sat32(64'(r16));
              k1 <= sat32(64'(r16) + 64'sd65536);
            end
            OP_KM: a_tmp <= r16;
            OP_KT: begin
              model <= m_new;
              e     <= e_new;
              prior <= e_new;
              dd    <= sat32(64'(prior) - 64'(e_new));
              mt    <= sat32(64'(m_new) - 64'(target));
            end
            OP_D: d <= term;
            OP_TERM: begin
              acc <= '0;
              if (cfg.windowed_integral) begin
                wsum  <= wsum_next;
                integ <= sat32(64'(wsum_next));
              end else begin
                integ <= sat32(64'(integ) + 64'(term));
              end
            end
            default: acc <= acc + rsel;
          endcase
          if (step == OP_LAST) begin
            busy      <= 1'b0;
            drive_sum <= sat32(64'(acc + rsel));
          end else begin
            step <= step + 4'd1;
          end
        end
      end
    end
  end

  assign stat.done      = done;
  assign stat.drive_sum = drive_sum;

endmodule

// File: rtl/fwmrp_merge.sv
// ----------------------------------------------------------------------------
// fwmrp_merge
// Maps the four lane sums through the inverse matrix, one product per step.
// ----------------------------------------------------------------------------
module fwmrp_merge import fwmrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] drive_sum [NW],
  output logic               done,
  output logic signed [31:0] drive [NW]
);

  logic               busy, phase;
  logic [3:0]         idx;
  logic [1:0]         row, col;
  logic signed [63:0] prod;
  logic signed [39:0] acc;
  logic signed [39:0] acc_next;

  assign row      = idx[3:2];
  assign col      = idx[1:0];
  assign acc_next = ((col == 2'd0) ? 40'sd0 : acc) + 40'(rnd28(prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && phase && !start && (idx == 4'hf);
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        idx   <= '0;
      end else if (busy) begin
        if (!phase) begin
          prod  <= INV_M1[row][col] * drive_sum[col];
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          acc   <= acc_next;
          if (col == 2'd3) drive[row] <= sat32(64'(acc_next));
          if (idx == 4'hf) begin
            busy <= 1'b0;
          end
          idx <= idx + 4'd1;
        end
      end
    end
  end

endmodule

// File: rtl/four_wheel_model_reference_pid.sv
// ----------------------------------------------------------------------------
// four_wheel_model_reference_pid
// Four-wheel PID with speed-model tracking and decoupling matrices, Q16.16.
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// s_*     | in  | target_speed_0..3, measured_speed_0..3
// m_*     | out | drive_0..3
// cfg_*   | in  | register index, write data
//
// After the input beat the lanes are started, each wheel lane runs 13
// products on its own multiplier, the sums are handed off and the merge
// unit is started, the merge unit runs 16 products, and the result is
// held and presented on m_tvalid. A new beat is taken only once the last
// result is in the output register. After reset a clearing pass zeroes
// the windows. While a result waits on m_tready the next beat is still
// taken; s_tready stays low once that beat's result is ready behind it.
// ----------------------------------------------------------------------------
module four_wheel_model_reference_pid import fwmrp_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // target_speed_0..3, measured_speed_0..3
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // drive_0..3
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LANE  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t             state;
  cfg_t               cfg;
  logic [HW-1:0]      head, clr_addr, addr;
  logic               clr_busy, start;
  logic signed [31:0] target [NW];
  logic signed [31:0] meas [NW];
  lane_ctl_t          ctl;
  lane_stat_t         stat [NW];
  logic signed [31:0] sums [NW];
  logic signed [31:0] drive [NW];
  logic               merge_start, merge_done, accept, all_done;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !clr_busy;
  assign accept    = s_tvalid && s_tready;
  assign addr      = clr_busy ? clr_addr : head;
  assign ctl.start  = start;
  assign ctl.clr_en = clr_busy;
  assign all_done  = stat[0].done && stat[1].done && stat[2].done && stat[3].done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= '0;
      cfg.integ_gain        <= '0;
      cfg.deriv_gain        <= '0;
      cfg.model_rate        <= '0;
      cfg.windowed_integral <= 1'b1;
      cfg.step_time         <= 31'd65;
      cfg.step_rate         <= 31'd65536000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP:      cfg.prop_gain         <= cfg_data;
        REG_INTEG:     cfg.integ_gain        <= cfg_data;
        REG_DERIV:     cfg.deriv_gain        <= cfg_data;
        REG_RATE:      cfg.model_rate        <= cfg_data;
        REG_WINDOWED:  cfg.windowed_integral <= cfg_data[0];
        REG_STEP_TIME: cfg.step_time         <= cfg_data[30:0];
        REG_STEP_RATE: cfg.step_rate         <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == HW'(WINDOW_DEPTH - 1)) clr_busy <= 1'b0;
      else clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NW; i++) begin
        target[i] <= s_tdata[32*i +: 32];
        meas[i]   <= s_tdata[32*(NW+i) +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      start       <= 1'b0;
      merge_start <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      start       <= accept;
      merge_start <= (state == ST_LANE) && all_done;
      m_tvalid    <= ((state == ST_HOLD) && (!m_tvalid || m_tready)) ||
                     (m_tvalid && !m_tready);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LANE;
            if (cfg.windowed_integral) begin
              head <= (head == HW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
            end
          end
        end
        ST_LANE: begin
          if (all_done) state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (merge_done) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && (!m_tvalid || m_tready)) begin
      for (int i = 0; i < NW; i++) m_tdata[32*i +: 32] <= drive[i];
    end
  end

  for (genvar g = 0; g < NW; g++) begin : g_lane
    fwmrp_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .LANE(g)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .addr   (addr),
      .cfg    (cfg),
      .target (target[g]),
      .meas   (meas),
      .stat   (stat[g])
    );
    assign sums[g] = stat[g].drive_sum;
  end

  fwmrp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .drive_sum (sums),
    .done      (merge_done),
    .drive     (drive)
  );

endmodule

// File: rtl/fwmrp_checker.sv
// ----------------------------------------------------------------------------
// fwmrp_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module fwmrp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared right after input");

endmodule

bind four_wheel_model_reference_pid fwmrp_checker u_fwmrp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: bench/four_wheel_model_reference_pid_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_wheel_model_reference_pid_test
// Drives speed beats through the controller under several gain, period and
// integral-mode settings. A local fixed-point model of the four wheel loops
// predicts each drive beat, which is checked field by field on the output.
// ----------------------------------------------------------------------------
module four_wheel_model_reference_pid_test;
  import fwmrp_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WIN = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  four_wheel_model_reference_pid i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // controller state as predicted
  longint kp, ki, kd, lam, ts, tr;
  bit     win_mode;
  longint mdl_spd[4], last_err[4], integ[4];
  longint err_win[4][WIN];
  int     head;

  logic [127:0] drive_due[$];
  int errors = 0;
  int tx_idle = 0, rx_idle = 0, rx_hold = 0;
  int cycles = 0;

  function automatic longint clamp(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, int s);
    longint p;
    p = a * b;
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_PROP:      kp = longint'($signed(v));
      REG_INTEG:     ki = longint'($signed(v));
      REG_DERIV:     kd = longint'($signed(v));
      REG_RATE:      lam = longint'($signed(v));
      REG_WINDOWED:  win_mode = v[0];
      REG_STEP_TIME: ts = longint'({33'd0, v[30:0]});
      REG_STEP_RATE: tr = longint'({33'd0, v[30:0]});
      default: ;
    endcase
  endfunction

  function automatic logic [127:0] control_tick(logic [255:0] d);
    longint tgt[4], ms[4], u[4];
    longint k1, k2, m, e, dv, term, acc, sum;
    logic [127:0] r;
    for (int i = 0; i < 4; i++) begin
      tgt[i] = longint'($signed(d[32*i +: 32]));
      ms[i]  = longint'($signed(d[128 + 32*i +: 32]));
    end
    k1 = clamp(65536 + qmul(ts, lam, 16));
    k2 = clamp(qmul(lam, ts, 16));
    if (win_mode) head = (head + 1) % WIN;
    for (int i = 0; i < 4; i++) begin
      m = clamp(qmul(k1, mdl_spd[i], 16) - qmul(k2, tgt[i], 16));
      mdl_spd[i] = m;
      e = clamp(m - ms[i]);
      dv = clamp(qmul(clamp(last_err[i] - e), tr, 16));
      last_err[i] = e;
      term = clamp(qmul(e, ts, 16));
      if (win_mode) begin
        err_win[i][head] = term;
        sum = 0;
        for (int j = 0; j < WIN; j++) sum += err_win[i][j];
        integ[i] = clamp(sum);
      end else begin
        integ[i] = clamp(integ[i] + term);
      end
      acc = qmul(kp, e, 16) + qmul(ki, integ[i], 16) + qmul(kd, dv, 16)
          + qmul(lam, clamp(m - tgt[i]), 16);
      for (int j = 0; j < 4; j++) acc += qmul(MODEL_M2[i][j], ms[j], 28);
      u[i] = clamp(acc);
    end
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += qmul(INV_M1[i][j], u[j], 28);
      r[32*i +: 32] = 32'(clamp(acc));
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // entered and left at a falling edge
  task automatic send_speeds(logic [255:0] d, bit typed, logic [127:0] typed_drive);
    logic [127:0] pred;
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid = 0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = control_tick(d);
    drive_due.push_back(typed ? typed_drive : pred);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid = 0;
    while (drive_due.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_speed();
    int c;
    c = $urandom_range(9);
    if (c < 7) return $urandom_range(2097151) - 1048576;
    if (c < 9) return $urandom;
    case ($urandom_range(2))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return 32'h0;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_due.size() == 0) begin
        $error("unexpected drive beat %h", m_tdata);
        errors++;
      end else begin
        want = drive_due.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
            $error("drive_%0d expected %0d got %0d", i,
                   $signed(want[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
            errors++;
          end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  typedef struct {
    logic [255:0] speeds;
    bit           typed;
    logic [127:0] drive;
  } speed_row_t;

  speed_row_t rows[12];
  logic [31:0] regs[7];

  initial begin
    kp = 0; ki = 0; kd = 0; lam = 0; win_mode = 1; ts = 65; tr = 65536000;
    head = 0;
    for (int i = 0; i < 4; i++) begin
      mdl_spd[i] = 0; last_err[i] = 0; integ[i] = 0;
      for (int j = 0; j < WIN; j++) err_win[i][j] = 0;
    end

    // zero gains and zero state: all-zero speeds give all-zero drive
    rows[0]  = '{'0, 1, '0};
    rows[1]  = '{'0, 1, '0};
    rows[2]  = '{{8{32'h7fffffff}}, 0, '0};
    rows[3]  = '{{8{32'h80000000}}, 0, '0};
    rows[4]  = '{{{4{32'h80000000}}, {4{32'h7fffffff}}}, 0, '0};
    rows[5]  = '{{{4{32'h7fffffff}}, {4{32'h80000000}}}, 0, '0};
    rows[6]  = '{{8{32'haaaaaaaa}}, 0, '0};
    rows[7]  = '{{8{32'h55555555}}, 0, '0};
    rows[8]  = '{{{4{32'h0}}, 32'h0, 32'h0, 32'h0, 32'h00010000}, 0, '0};
    rows[9]  = '{{{4{32'h00010000}}, {4{32'h0}}}, 0, '0};
    rows[10] = '{{8{32'hffffffff}}, 0, '0};
    rows[11] = '{{8{32'h00000001}}, 0, '0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[r]) send_speeds(rows[r].speeds, rows[r].typed, rows[r].drive);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1,
                    32'h7fffffff, 32'h7fffffff};
        1: regs = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0};
        4: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        default: begin
          regs[REG_PROP] = $urandom_range(262143);
          regs[REG_INTEG] = $urandom_range(131071);
          regs[REG_DERIV] = $urandom_range(4095);
          regs[REG_RATE] = -$urandom_range(131071);
          regs[REG_WINDOWED] = 32'(ph != 2);
          regs[REG_STEP_TIME] = $urandom_range(1, 6553);
          regs[REG_STEP_RATE] = $urandom_range(65536, 65536000);
        end
      endcase
      for (int k = 0; k < 7; k++) write_reg(3'(k), regs[k]);
      write_reg(REG_UNUSED, $urandom);

      if (ph < 2) begin
        tx_idle = 22; rx_idle = 84;
      end else if (ph < 4) begin
        tx_idle = 84; rx_idle = 22;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      if (ph == 4) rx_hold = 600;

      for (int n = 0; n < 100; n++) begin
        logic [255:0] d;
        for (int f = 0; f < 8; f++) d[32*f +: 32] = rand_speed();
        send_speeds(d, 0, '0);
      end
      settle();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
